/* rtl/core/bsdc_pkg.sv */
// ----------------------------------------------------------------------------
// bsdc_pkg - shared definitions for the bitmap sort core
// Request kinds, result codes, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package bsdc_pkg;

  localparam int MODE_W      = 2;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 3;
  localparam int SORTED_W    = 12;
  localparam int BYTE_W      = 8;
  localparam int BIT_SEL_W   = 3;
  localparam int OUT_DATA_W  = 16;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FETCH  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_VALUE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_END       = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REFUSED   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_WAIT
  } state_t;

endpackage

`default_nettype wire

/* rtl/core/bsdc_ram.sv */
// ----------------------------------------------------------------------------
// bsdc_ram - generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bsdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/bitmap_sort_with_duplicate_check_core.sv */
// ----------------------------------------------------------------------------
// bitmap_sort_with_duplicate_check_core - bitmap sort with duplicate check
// Inserts values into a byte-wide bitmap RAM and returns them in ascending
// order on fetch requests; duplicates raise a sticky error.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one request per handshake: in_tuser selects
//   insert, fetch or clear, and in_tdata carries the value for an insert.
//   Every insert, fetch and clear returns exactly one result on the output
//   channel; a request of the unused kind is taken and returns nothing.
//   Requests are processed one at a time.
//   Insert: accept, then read-modify-write of one bitmap byte.
//   Fetch: accept, then a read of each bitmap byte in turn until a set bit
//   or the end is found; the single RAM read port scans one byte per cycle.
//   Clear: a zeroing sweep of the whole bitmap, one byte per cycle.
//   After reset the core sweeps all VALUE_COUNT/8 bitmap bytes (512 at
//   the default) with in_tready low, then becomes ready.
//   A finished result sits in an output register; the next request is
//   accepted while it waits. If the receiver stalls and a second result is
//   ready, it is held and no further request is taken until it moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_sort_with_duplicate_check_core #(
  parameter int VALUE_COUNT = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // value[31:0]
  input  wire logic [1:0]  in_tuser,   // mode[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // sorted_value[11:0], zero fill [15:12]
  output logic [2:0]       out_tuser   // status[2:0]
);

  localparam int DEPTH = VALUE_COUNT / bsdc_pkg::BYTE_W;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = $clog2(VALUE_COUNT + 1);
  localparam int BW    = SW - bsdc_pkg::BIT_SEL_W;

  bsdc_pkg::state_t state_r, state_nxt;

  logic [SW-1:0]                    scan_r, scan_nxt;
  logic                             err_r, err_nxt;
  logic [bsdc_pkg::MODE_W-1:0]      op_r, op_nxt;
  logic                             oor_r, oor_nxt;
  logic [AW-1:0]                    ins_addr_r, ins_addr_nxt;
  logic [bsdc_pkg::BIT_SEL_W-1:0]   ins_bit_r, ins_bit_nxt;
  logic [AW-1:0]                    clr_cnt_r, clr_cnt_nxt;
  logic                             clr_report_r, clr_report_nxt;
  logic [bsdc_pkg::STATUS_W-1:0]    pend_status_r, pend_status_nxt;
  logic [bsdc_pkg::SORTED_W-1:0]    pend_value_r, pend_value_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [bsdc_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [bsdc_pkg::SORTED_W-1:0]    out_value_r, out_value_nxt;

  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr;
  logic [bsdc_pkg::BYTE_W-1:0]      ram_wdata;
  logic [AW-1:0]                    ram_raddr;
  logic [bsdc_pkg::BYTE_W-1:0]      ram_rdata;

  logic                             accept;
  logic                             out_free;
  logic                             res_valid;
  logic [bsdc_pkg::STATUS_W-1:0]    res_status;
  logic [bsdc_pkg::SORTED_W-1:0]    res_value;
  logic                             scan_more;
  logic                             clr_last;
  logic [BW-1:0]                    cur_byte;
  logic [BW-1:0]                    nxt_byte;
  logic [bsdc_pkg::BYTE_W-1:0]      masked;
  logic                             found;
  logic [bsdc_pkg::BIT_SEL_W-1:0]   found_bit;
  logic [SW-1:0]                    found_val;
  logic [bsdc_pkg::SORTED_W-1:0]    found_ext;

  bsdc_ram #(
    .WIDTH (bsdc_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == bsdc_pkg::S_IDLE);
  assign accept     = in_tvalid & in_tready;
  assign out_free   = ~out_valid_r | out_tready;
  assign clr_last   = (clr_cnt_r == AW'(DEPTH - 1));

  assign cur_byte   = scan_r[SW-1:bsdc_pkg::BIT_SEL_W];
  assign nxt_byte   = cur_byte + BW'(1);
  assign masked     = ram_rdata & (8'hFF << scan_r[bsdc_pkg::BIT_SEL_W-1:0]);
  assign found      = (masked != '0);
  assign found_val  = {cur_byte, found_bit};
  assign found_ext  = bsdc_pkg::SORTED_W'(found_val);

  always_comb begin
    found_bit = '0;
    for (int i = bsdc_pkg::BYTE_W - 1; i >= 0; i--) begin
      if (masked[i]) begin
        found_bit = bsdc_pkg::BIT_SEL_W'(i);
      end
    end
  end

  // Datapath and result selection.
  always_comb begin
    scan_nxt        = scan_r;
    err_nxt         = err_r;
    op_nxt          = op_r;
    oor_nxt         = oor_r;
    ins_addr_nxt    = ins_addr_r;
    ins_bit_nxt     = ins_bit_r;
    clr_cnt_nxt     = clr_cnt_r;
    clr_report_nxt  = clr_report_r;
    pend_status_nxt = pend_status_r;
    pend_value_nxt  = pend_value_r;
    ram_we          = 1'b0;
    ram_waddr       = ins_addr_r;
    ram_wdata       = ram_rdata;
    ram_raddr       = ins_addr_r;
    res_valid       = 1'b0;
    res_status      = bsdc_pkg::ST_INSERTED;
    res_value       = '0;
    scan_more       = 1'b0;

    unique case (state_r)
      bsdc_pkg::S_IDLE: begin
        op_nxt       = in_tuser;
        oor_nxt      = (in_tdata >= 32'(VALUE_COUNT));
        ins_addr_nxt = in_tdata[AW+bsdc_pkg::BIT_SEL_W-1:bsdc_pkg::BIT_SEL_W];
        ins_bit_nxt  = in_tdata[bsdc_pkg::BIT_SEL_W-1:0];
        if (in_tuser == bsdc_pkg::MODE_FETCH) begin
          ram_raddr = scan_r[AW+bsdc_pkg::BIT_SEL_W-1:bsdc_pkg::BIT_SEL_W];
        end else begin
          ram_raddr = in_tdata[AW+bsdc_pkg::BIT_SEL_W-1:bsdc_pkg::BIT_SEL_W];
        end
        if (accept && in_tuser == bsdc_pkg::MODE_CLEAR) begin
          clr_cnt_nxt    = '0;
          clr_report_nxt = 1'b1;
          scan_nxt       = '0;
          err_nxt        = 1'b0;
        end
      end

      bsdc_pkg::S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_last) begin
          res_valid  = clr_report_r;
          res_status = bsdc_pkg::ST_CLEARED;
        end
      end

      bsdc_pkg::S_READ: begin
        res_valid = 1'b1;
        if (op_r == bsdc_pkg::MODE_INSERT) begin
          if (oor_r) begin
            res_status = bsdc_pkg::ST_RANGE;
          end else if (ram_rdata[ins_bit_r]) begin
            res_status = bsdc_pkg::ST_DUPLICATE;
            err_nxt    = 1'b1;
          end else begin
            res_status = bsdc_pkg::ST_INSERTED;
            ram_we     = 1'b1;
            ram_wdata  = ram_rdata | (8'h01 << ins_bit_r);
          end
        end else if (err_r) begin
          res_status = bsdc_pkg::ST_REFUSED;
        end else if (cur_byte == BW'(DEPTH)) begin
          res_status = bsdc_pkg::ST_END;
        end else if (found) begin
          res_status = bsdc_pkg::ST_VALUE;
          res_value  = found_ext;
          scan_nxt   = found_val + SW'(1);
        end else begin
          // Nothing left in this byte: step to the next one, or stop at the end.
          scan_nxt = {nxt_byte, bsdc_pkg::BIT_SEL_W'(0)};
          if (nxt_byte == BW'(DEPTH)) begin
            res_status = bsdc_pkg::ST_END;
          end else begin
            res_valid = 1'b0;
            scan_more = 1'b1;
            ram_raddr = nxt_byte[AW-1:0];
          end
        end
      end

      bsdc_pkg::S_WAIT: begin
      end

      default: begin
      end
    endcase

    if (res_valid && !out_free) begin
      pend_status_nxt = res_status;
      pend_value_nxt  = res_value;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bsdc_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_tuser) inside
            bsdc_pkg::MODE_INSERT, bsdc_pkg::MODE_FETCH: state_nxt = bsdc_pkg::S_READ;
            bsdc_pkg::MODE_CLEAR:                        state_nxt = bsdc_pkg::S_CLEAR;
            default:                                     state_nxt = bsdc_pkg::S_IDLE;
          endcase
        end
      end
      bsdc_pkg::S_CLEAR: begin
        if (clr_last) begin
          state_nxt = (res_valid && !out_free) ? bsdc_pkg::S_WAIT : bsdc_pkg::S_IDLE;
        end
      end
      bsdc_pkg::S_READ: begin
        if (!scan_more) begin
          state_nxt = out_free ? bsdc_pkg::S_IDLE : bsdc_pkg::S_WAIT;
        end
      end
      bsdc_pkg::S_WAIT: begin
        if (out_free) begin
          state_nxt = bsdc_pkg::S_IDLE;
        end
      end
      default: state_nxt = bsdc_pkg::S_IDLE;
    endcase
  end

  // Output register loading.
  always_comb begin
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    if (state_r == bsdc_pkg::S_WAIT && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = pend_status_r;
      out_value_nxt  = pend_value_r;
    end else if (res_valid && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status;
      out_value_nxt  = res_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bsdc_pkg::S_CLEAR;
      scan_r       <= '0;
      err_r        <= 1'b0;
      clr_cnt_r    <= '0;
      clr_report_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_r       <= scan_nxt;
      err_r        <= err_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_report_r <= clr_report_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    oor_r         <= oor_nxt;
    ins_addr_r    <= ins_addr_nxt;
    ins_bit_r     <= ins_bit_nxt;
    pend_status_r <= pend_status_nxt;
    pend_value_r  <= pend_value_nxt;
    out_status_r  <= out_status_nxt;
    out_value_r   <= out_value_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {(bsdc_pkg::OUT_DATA_W - bsdc_pkg::SORTED_W)'(0), out_value_r};

endmodule

`default_nettype wire

/* sim/bitmap_sort_checker.sv */
// ----------------------------------------------------------------------------
// bitmap_sort_checker - result checker for the bitmap sort core
// Watches both stream channels, keeps a shadow bitmap with scan position and
// duplicate flag, predicts the reply to every accepted request that has one
// and compares each reply taken from the core with the oldest one still due.
// ----------------------------------------------------------------------------
module bitmap_sort_checker #(
  parameter int VALUE_COUNT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // sorted_value[11:0], zero fill [15:12]
  input  logic [2:0]  out_tuser,  // status[2:0]
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import bsdc_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SORTED_W-1:0] sorted_value;
  } reply_t;

  logic [VALUE_COUNT-1:0] shadow_bits;
  int unsigned            shadow_scan;
  bit                     shadow_dup_error;
  reply_t                 replies_due[$];
  reply_t                 oldest_reply;
  reply_t                 new_reply;
  int                     mismatches = 0;

  // Updates the shadow state for one request; returns 0 for the unused mode,
  // which produces no reply.
  function automatic bit predict_reply(input logic [MODE_W-1:0] mode,
                                       input logic [VALUE_W-1:0] value,
                                       output reply_t reply);
    reply = '0;
    case (mode)
      MODE_INSERT: begin
        if (value >= VALUE_COUNT) begin
          reply.status = ST_RANGE;
        end else if (shadow_bits[value]) begin
          shadow_dup_error = 1'b1;
          reply.status = ST_DUPLICATE;
        end else begin
          shadow_bits[value] = 1'b1;
          reply.status = ST_INSERTED;
        end
        return 1'b1;
      end
      MODE_FETCH: begin
        if (shadow_dup_error) begin
          reply.status = ST_REFUSED;
        end else begin
          // The scan rests at the end of the bitmap once it has run out.
          reply.status = ST_END;
          while (shadow_scan < VALUE_COUNT && reply.status == ST_END) begin
            if (shadow_bits[shadow_scan]) begin
              reply.status = ST_VALUE;
              reply.sorted_value = shadow_scan[SORTED_W-1:0];
            end
            shadow_scan++;
          end
        end
        return 1'b1;
      end
      MODE_CLEAR: begin
        shadow_bits      = '0;
        shadow_scan      = 0;
        shadow_dup_error = 1'b0;
        reply.status     = ST_CLEARED;
        return 1'b1;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  task automatic note_mismatch(input string detail);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t ns: %s", $time, detail);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_bits      = '0;
      shadow_scan      = 0;
      shadow_dup_error = 1'b0;
      replies_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (replies_due.size() == 0) begin
          note_mismatch($sformatf("reply with no request waiting: status %0d, data %0d",
                                  out_tuser, out_tdata));
        end else begin
          oldest_reply = replies_due.pop_front();
          if (out_tuser !== oldest_reply.status) begin
            note_mismatch($sformatf("status: expected %0d, got %0d",
                                    oldest_reply.status, out_tuser));
          end
          if (out_tdata !== {{(OUT_DATA_W-SORTED_W){1'b0}}, oldest_reply.sorted_value}) begin
            note_mismatch($sformatf("sorted value: expected %0d, got %0d",
                                    oldest_reply.sorted_value, out_tdata));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (predict_reply(in_tuser, in_tdata, new_reply)) begin
          replies_due.push_back(new_reply);
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= replies_due.size();
  end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top - testbench for the bitmap sort core
// Drives insert, fetch and clear requests with random gaps and back-pressure:
// a directed opening covers the corner cases, then random runs insert sets
// of values and read them back in order. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bsdc_pkg::*;

  localparam int VALUE_COUNT = 4096;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = MODE_INSERT;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;

  int fail_count;
  int pending_count;
  int send_idle_pct = 28;
  int recv_idle_pct = 71;
  int requests_sent = 0;

  bitmap_sort_with_duplicate_check_core #(
    .VALUE_COUNT(VALUE_COUNT)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  bitmap_sort_checker #(
    .VALUE_COUNT(VALUE_COUNT)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Presents one request, with a random gap first, and returns at the rising
  // edge where it is taken.
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [31:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      in_tuser  <= MODE_W'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    if (mode != MODE_NONE) begin
      requests_sent++;
    end
  endtask

  task automatic wait_all_replies;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // Mostly well-formed runs: clear, insert a set of distinct values in random
  // order, then fetch them all back and past the end. Duplicates, values out
  // of range, inserts during the read-back and loose noise are mixed in.
  task automatic run_random(input int quota);
    int          stop_at;
    int          pick;
    int          set_size;
    int          step_max;
    int          v;
    int          idx;
    logic [31:0] pool[$];
    logic [31:0] placed[$];
    stop_at = requests_sent + quota;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        if ($urandom_range(99) < 85) begin
          send_request(MODE_CLEAR, $urandom);
        end
        set_size = ($urandom_range(99) < 5) ? $urandom_range(30, 60) : $urandom_range(1, 12);
        step_max = ($urandom_range(1) == 1) ? 8 : 400;
        pool.delete();
        placed.delete();
        v = $urandom_range(0, VALUE_COUNT - 1) / 2;
        repeat (set_size) begin
          pool.push_back(v);
          v += $urandom_range(1, step_max);
        end
        while (pool.size() != 0) begin
          idx = $urandom_range(0, pool.size() - 1);
          if ($urandom_range(99) < 3 && placed.size() != 0) begin
            send_request(MODE_INSERT, placed[$urandom_range(0, placed.size() - 1)]);
          end else if ($urandom_range(99) < 4) begin
            send_request(MODE_INSERT, $urandom_range(32'hFFFF_FFFF, VALUE_COUNT));
          end else begin
            send_request(MODE_INSERT, pool[idx]);
            placed.push_back(pool[idx]);
            pool.delete(idx);
          end
        end
        repeat (placed.size() + $urandom_range(1, 3)) begin
          if ($urandom_range(99) < 10) begin
            send_request(MODE_INSERT, $urandom_range(0, VALUE_COUNT - 1));
          end else begin
            send_request(MODE_FETCH, $urandom);
          end
        end
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 6)) begin
          send_request(MODE_W'($urandom_range(0, 3)),
                       ($urandom_range(1) == 1) ? $urandom : $urandom_range(0, VALUE_COUNT - 1));
        end
      end else begin
        send_request(MODE_NONE, $urandom);
        send_request(MODE_FETCH, $urandom);
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    send_request(MODE_FETCH, 32'd0);
    send_request(MODE_INSERT, 32'd0);
    send_request(MODE_INSERT, VALUE_COUNT - 1);
    send_request(MODE_INSERT, 32'd7);
    send_request(MODE_INSERT, 32'd8);
    send_request(MODE_INSERT, VALUE_COUNT);
    send_request(MODE_INSERT, 32'hFFFF_FFFF);
    send_request(MODE_FETCH, $urandom);
    send_request(MODE_FETCH, $urandom);
    // Three now lies behind the scan and must not come back before a clear.
    send_request(MODE_INSERT, 32'd3);
    send_request(MODE_FETCH, $urandom);
    send_request(MODE_FETCH, $urandom);
    send_request(MODE_FETCH, $urandom);
    send_request(MODE_FETCH, $urandom);
    send_request(MODE_NONE, $urandom);
    send_request(MODE_CLEAR, $urandom);
    send_request(MODE_INSERT, 32'd5);
    send_request(MODE_INSERT, 32'd5);
    send_request(MODE_FETCH, $urandom);
    send_request(MODE_INSERT, 32'd2);
    send_request(MODE_CLEAR, $urandom);
    send_request(MODE_FETCH, $urandom);
    send_request(MODE_INSERT, 32'd2);
    send_request(MODE_FETCH, $urandom);
    wait_all_replies();

    run_random(350);
    wait_all_replies();
    @(posedge clk);
    send_idle_pct = 71;
    recv_idle_pct = 28;
    run_random(350);
    wait_all_replies();
    @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(350);
    wait_all_replies();

    repeat (VALUE_COUNT / 8 + 8) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/bsdc_pkg.sv
rtl/core/bsdc_ram.sv
rtl/core/bitmap_sort_with_duplicate_check_core.sv
sim/bitmap_sort_checker.sv
sim/tb_top.sv
